@@ hw/rtl/h2d_pkg.sv @@
package h2d_pkg;

   localparam int FUNC_W      = 3;
   localparam int INDEX_W     = 8;
   localparam int BINS_REG_W  = 5;
   localparam int BIN_PORT_W  = 4;
   localparam int TOTAL_W     = 24;
   localparam int CSR_INDEX_W = 1;

   localparam logic [CSR_INDEX_W-1:0] CSR_BINS_X = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BINS_Y = 1'b1;

   localparam logic [BINS_REG_W-1:0] BINS_RESET = 5'd16;
   localparam logic [TOTAL_W-1:0]    TOTAL_MAX  = {TOTAL_W{1'b1}};

   typedef enum logic [FUNC_W-1:0] {
      FN_LOAD_X = 3'd0,
      FN_LOAD_Y = 3'd1,
      FN_ADD    = 3'd2,
      FN_READ   = 3'd3,
      FN_CLEAR  = 3'd4
   } func_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOCATE,
      ST_FETCH,
      ST_UPDATE
   } state_type;

endpackage

@@ hw/rtl/histogram_2d_binning.sv @@
// Channel   Ports                                    Handshake
// request   req_func req_index req_x_value req_y_value  accepted when start && !busy
// result    rsp_in_range rsp_bin_x rsp_bin_y rsp_count rsp_total  one cycle, rsp_valid
// control   csr_index csr_data                         written when csr_wr_en
//
// Every item passes three steps: bin search, counter fetch, counter update.
// The result appears the cycle after the update; a new item is taken in the
// update cycle, so busy, raised during bin search and counter fetch, is the
// interlock for the read-modify-write of the counter memory.
// Reset is synchronous; counters read as zero after reset or clear through
// per-counter valid flags. The receiver cannot stall results.
module histogram_2d_binning #(
   parameter int MAX_BINS    = 16,
   parameter int COUNT_WIDTH = 16,
   parameter int VALUE_WIDTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [h2d_pkg::FUNC_W-1:0]        req_func,
   input  logic [h2d_pkg::INDEX_W-1:0]       req_index,
   input  logic signed [VALUE_WIDTH-1:0]     req_x_value,
   input  logic signed [VALUE_WIDTH-1:0]     req_y_value,
   output logic                              rsp_valid,
   output logic                              rsp_in_range,
   output logic [h2d_pkg::BIN_PORT_W-1:0]    rsp_bin_x,
   output logic [h2d_pkg::BIN_PORT_W-1:0]    rsp_bin_y,
   output logic [COUNT_WIDTH-1:0]            rsp_count,
   output logic [h2d_pkg::TOTAL_W-1:0]       rsp_total,
   input  logic                              csr_wr_en,
   input  logic [h2d_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [h2d_pkg::BINS_REG_W-1:0]    csr_data
);
   import h2d_pkg::*;

   localparam int NB_W   = $clog2(MAX_BINS + 1);
   localparam int BIN_W  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
   localparam int CELLS  = MAX_BINS * MAX_BINS;
   localparam int CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int PROD_W = BIN_W + NB_W;
   localparam int SUM_W  = PROD_W + 1;
   localparam int DIF_W  = INDEX_W + PROD_W;

   function automatic logic [NB_W-1:0] clamp_bins(input logic [BINS_REG_W-1:0] r);
      logic [NB_W-1:0] v;
      if (r == '0) begin
         v = NB_W'(1);
      end else if (int'(r) > MAX_BINS) begin
         v = NB_W'(MAX_BINS);
      end else begin
         v = NB_W'(r);
      end
      return v;
   endfunction

   // control state
   state_type state_ff, state_in;
   logic [BINS_REG_W-1:0] bins_x_ff, bins_y_ff;
   logic [TOTAL_W-1:0]    total_ff, total_in;
   logic [CELLS-1:0]      vld_ff;
   logic                  rsp_valid_ff;

   // item payload
   logic [FUNC_W-1:0]             func_ff;
   logic [INDEX_W-1:0]            index_ff;
   logic signed [VALUE_WIDTH-1:0] x_ff, y_ff;
   logic                          hit_ff;
   logic [BIN_W-1:0]              bx_ff, by_ff;
   logic [CELL_W-1:0]             addr_ff;
   logic                          cell_vld_ff;

   logic                   rsp_in_range_ff, rsp_in_range_in;
   logic [BIN_PORT_W-1:0]  rsp_bin_x_ff, rsp_bin_x_in;
   logic [BIN_PORT_W-1:0]  rsp_bin_y_ff, rsp_bin_y_in;
   logic [COUNT_WIDTH-1:0] rsp_count_ff, rsp_count_in;

   logic                   accept;
   logic [NB_W-1:0]        nx, ny;
   logic                   hit_x, hit_y;
   logic [BIN_W-1:0]       bin_x, bin_y;
   logic                   rd_ok;
   logic [BIN_W-1:0]       rd_row;
   logic [PROD_W-1:0]      row_base;
   logic [SUM_W-1:0]       flat_sum;
   logic [CELL_W-1:0]      fetch_addr;
   logic [COUNT_WIDTH-1:0] rd_data;
   logic [COUNT_WIDTH-1:0] cur_count, inc_count;
   logic                   ram_rd_en, ram_wr_en;

   assign accept = start && !busy;
   assign nx = clamp_bins(bins_x_ff);
   assign ny = clamp_bins(bins_y_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         bins_x_ff <= BINS_RESET;
         bins_y_ff <= BINS_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_BINS_X: bins_x_ff <= csr_data;
            CSR_BINS_Y: bins_y_ff <= csr_data;
         endcase
      end
   end

   // edges load straight from the request at the accepting edge
   h2d_axis #(.MAX_BINS(MAX_BINS), .VALUE_WIDTH(VALUE_WIDTH)) u_axis_x (
      .clock      (clock),
      .reset      (reset),
      .load_en    (accept && (req_func == FN_LOAD_X)),
      .load_index (req_index),
      .load_value (req_x_value),
      .bins_used  (nx),
      .value      (x_ff),
      .hit        (hit_x),
      .bin        (bin_x)
   );

   h2d_axis #(.MAX_BINS(MAX_BINS), .VALUE_WIDTH(VALUE_WIDTH)) u_axis_y (
      .clock      (clock),
      .reset      (reset),
      .load_en    (accept && (req_func == FN_LOAD_Y)),
      .load_index (req_index),
      .load_value (req_x_value),
      .bins_used  (ny),
      .value      (y_ff),
      .hit        (hit_y),
      .bin        (bin_y)
   );

   // row of a flat read address: count the row starts after the first at or below it
   always_comb begin
      rd_row = '0;
      for (int k = 1; k < MAX_BINS; k++) begin
         if (int'(index_ff) >= k * int'(nx)) begin
            rd_row = rd_row + BIN_W'(1);
         end
      end
   end

   assign rd_ok = int'(index_ff) < (int'(nx) * int'(ny));

   assign row_base = PROD_W'(by_ff) * PROD_W'(nx);
   assign flat_sum = SUM_W'(row_base) + SUM_W'(bx_ff);

   always_comb begin
      if (func_ff == FN_READ) begin
         fetch_addr = CELL_W'(index_ff);
      end else begin
         fetch_addr = CELL_W'(flat_sum);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff  <= req_func;
         index_ff <= req_index;
         x_ff     <= req_x_value;
         y_ff     <= req_y_value;
      end
      if (state_ff == ST_LOCATE) begin
         if (func_ff == FN_READ) begin
            hit_ff <= rd_ok;
            by_ff  <= rd_row;
         end else begin
            hit_ff <= hit_x && hit_y;
            bx_ff  <= bin_x;
            by_ff  <= bin_y;
         end
      end
      if (state_ff == ST_FETCH) begin
         addr_ff     <= fetch_addr;
         cell_vld_ff <= vld_ff[fetch_addr];
         if (func_ff == FN_READ) begin
            bx_ff <= BIN_W'(DIF_W'(index_ff) - DIF_W'(row_base));
         end
      end
   end

   assign ram_rd_en = (state_ff == ST_FETCH);
   assign ram_wr_en = (state_ff == ST_UPDATE) && (func_ff == FN_ADD) && hit_ff;

   h2d_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(CELLS)) u_counts (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (addr_ff),
      .wr_data (inc_count),
      .rd_en   (ram_rd_en),
      .rd_addr (fetch_addr),
      .rd_data (rd_data)
   );

   // a counter never written since reset or clear reads as zero
   assign cur_count = cell_vld_ff ? rd_data : '0;
   assign inc_count = (cur_count == {COUNT_WIDTH{1'b1}}) ? cur_count
                                                         : cur_count + COUNT_WIDTH'(1);

   always_comb begin
      total_in        = total_ff;
      rsp_in_range_in = 1'b0;
      rsp_bin_x_in    = '0;
      rsp_bin_y_in    = '0;
      rsp_count_in    = '0;
      case (func_ff)
         FN_ADD: begin
            if (total_ff != TOTAL_MAX) begin
               total_in = total_ff + TOTAL_W'(1);
            end
            if (hit_ff) begin
               rsp_in_range_in = 1'b1;
               rsp_bin_x_in    = BIN_PORT_W'(bx_ff);
               rsp_bin_y_in    = BIN_PORT_W'(by_ff);
               rsp_count_in    = inc_count;
            end
         end
         FN_READ: begin
            if (hit_ff) begin
               rsp_in_range_in = 1'b1;
               rsp_bin_x_in    = BIN_PORT_W'(bx_ff);
               rsp_bin_y_in    = BIN_PORT_W'(by_ff);
               rsp_count_in    = cur_count;
            end
         end
         FN_CLEAR: begin
            total_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= '0;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (state_ff == ST_UPDATE);
         if (state_ff == ST_UPDATE) begin
            total_ff <= total_in;
            if (func_ff == FN_CLEAR) begin
               vld_ff <= '0;
            end else if (ram_wr_en) begin
               vld_ff[addr_ff] <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_UPDATE) begin
         rsp_in_range_ff <= rsp_in_range_in;
         rsp_bin_x_ff    <= rsp_bin_x_in;
         rsp_bin_y_ff    <= rsp_bin_y_in;
         rsp_count_ff    <= rsp_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   state_in = start ? ST_LOCATE : ST_IDLE;
         ST_LOCATE: state_in = ST_FETCH;
         ST_FETCH:  state_in = ST_UPDATE;
         ST_UPDATE: state_in = start ? ST_LOCATE : ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // the update cycle already takes the next item
   always_comb begin
      unique case (state_ff)
         ST_LOCATE, ST_FETCH: busy = 1'b1;
         default:             busy = 1'b0;
      endcase
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_in_range = rsp_in_range_ff;
   assign rsp_bin_x    = rsp_bin_x_ff;
   assign rsp_bin_y    = rsp_bin_y_ff;
   assign rsp_count    = rsp_count_ff;
   assign rsp_total    = total_ff;

endmodule

@@ hw/rtl/h2d_ram.sv @@
module h2d_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/h2d_axis.sv @@
module h2d_axis #(
   parameter int MAX_BINS    = 16,
   parameter int VALUE_WIDTH = 16,
   localparam int NB_W  = $clog2(MAX_BINS + 1),
   localparam int BIN_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load_en,
   input  logic [h2d_pkg::INDEX_W-1:0]   load_index,
   input  logic signed [VALUE_WIDTH-1:0] load_value,
   input  logic [NB_W-1:0]               bins_used,
   input  logic signed [VALUE_WIDTH-1:0] value,
   output logic                          hit,
   output logic [BIN_W-1:0]              bin
);
   import h2d_pkg::*;

   localparam int EDGES = MAX_BINS + 1;
   localparam int CNT_W = $clog2(EDGES + 1);

   logic signed [VALUE_WIDTH-1:0] edge_ff [EDGES];
   logic [CNT_W-1:0]              below;
   logic signed [VALUE_WIDTH-1:0] last_edge;

   // each edge register watches its own index; loads beyond the table drop
   always_ff @(posedge clock) begin
      for (int i = 0; i < EDGES; i++) begin
         if (reset) begin
            edge_ff[i] <= '0;
         end else if (load_en && (int'(load_index) == i)) begin
            edge_ff[i] <= load_value;
         end
      end
   end

   assign last_edge = edge_ff[bins_used];

   always_comb begin
      below = '0;
      for (int i = 0; i < EDGES; i++) begin
         if ((i <= int'(bins_used)) && (edge_ff[i] <= value)) begin
            below = below + CNT_W'(1);
         end
      end
   end

   assign hit = (value >= edge_ff[0]) && (value <= last_edge);

   // clamp to the last bin when the value sits on the upper edge
   always_comb begin
      if (int'(below) > int'(bins_used)) begin
         bin = BIN_W'(bins_used - NB_W'(1));
      end else begin
         bin = BIN_W'(below - CNT_W'(1));
      end
   end

endmodule

@@ hw/rtl/h2d_checker.sv @@
module h2d_props #(
   parameter int COUNT_WIDTH = 16
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           start,
   input logic                           busy,
   input logic                           rsp_valid,
   input logic                           rsp_in_range,
   input logic [h2d_pkg::BIN_PORT_W-1:0] rsp_bin_x,
   input logic [h2d_pkg::BIN_PORT_W-1:0] rsp_bin_y,
   input logic [COUNT_WIDTH-1:0]         rsp_count
);
   import h2d_pkg::*;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after an accepted item");

   a_result_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##4 rsp_valid)
      else $error("result missing four cycles after accept");

   a_result_has_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 4))
      else $error("result without an accepted item");

   a_miss_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_in_range) |->
         (rsp_count == '0) && (rsp_bin_x == '0) && (rsp_bin_y == '0))
      else $error("result out of range carries nonzero fields");

endmodule

bind histogram_2d_binning h2d_props #(.COUNT_WIDTH(COUNT_WIDTH)) u_h2d_props (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .rsp_valid    (rsp_valid),
   .rsp_in_range (rsp_in_range),
   .rsp_bin_x    (rsp_bin_x),
   .rsp_bin_y    (rsp_bin_y),
   .rsp_count    (rsp_count)
);

@@ dv/h2d_checker.sv @@
`timescale 1ns / 100ps

module h2d_checker #(
   parameter int MAX_BINS    = 16,
   parameter int COUNT_WIDTH = 16,
   parameter int VALUE_WIDTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic                              busy,
   input  logic [h2d_pkg::FUNC_W-1:0]        req_func,
   input  logic [h2d_pkg::INDEX_W-1:0]       req_index,
   input  logic signed [VALUE_WIDTH-1:0]     req_x_value,
   input  logic signed [VALUE_WIDTH-1:0]     req_y_value,
   input  logic                              rsp_valid,
   input  logic                              rsp_in_range,
   input  logic [h2d_pkg::BIN_PORT_W-1:0]    rsp_bin_x,
   input  logic [h2d_pkg::BIN_PORT_W-1:0]    rsp_bin_y,
   input  logic [COUNT_WIDTH-1:0]            rsp_count,
   input  logic [h2d_pkg::TOTAL_W-1:0]       rsp_total,
   input  logic                              csr_wr_en,
   input  logic [h2d_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [h2d_pkg::BINS_REG_W-1:0]    csr_data,
   output int                                fail_count,
   output int                                outstanding
);

   import h2d_pkg::*;

   localparam int EDGE_DEPTH = MAX_BINS + 1;
   localparam int CELLS      = MAX_BINS * MAX_BINS;
   localparam logic [COUNT_WIDTH-1:0] COUNT_SAT = '1;

   typedef struct packed {
      logic                   in_range;
      logic [BIN_PORT_W-1:0]  bin_x;
      logic [BIN_PORT_W-1:0]  bin_y;
      logic [COUNT_WIDTH-1:0] count;
      logic [TOTAL_W-1:0]     total;
   } bin_report_type;

   logic signed [VALUE_WIDTH-1:0] x_edges [EDGE_DEPTH];
   logic signed [VALUE_WIDTH-1:0] y_edges [EDGE_DEPTH];
   logic [COUNT_WIDTH-1:0]        cell_counts [CELLS];
   logic [TOTAL_W-1:0]            samples_seen;
   logic [BINS_REG_W-1:0]         bins_x_reg;
   logic [BINS_REG_W-1:0]         bins_y_reg;
   bin_report_type                bin_reports [$];
   bin_report_type                want;

   function automatic int bins_in_use(input logic [BINS_REG_W-1:0] r);
      if (r == 0) return 1;
      if (r > MAX_BINS) return MAX_BINS;
      return int'(r);
   endfunction

   // bin = edges at or below v, minus one, clamped to the top bin
   function automatic bit find_bin(input bit on_y, input int n,
                                   input logic signed [VALUE_WIDTH-1:0] v,
                                   output int bin);
      int at_or_below;
      int i;
      logic signed [VALUE_WIDTH-1:0] e;
      at_or_below = 0;
      bin = 0;
      e = on_y ? y_edges[0] : x_edges[0];
      if (v < e) return 1'b0;
      e = on_y ? y_edges[n] : x_edges[n];
      if (v > e) return 1'b0;
      for (i = 0; i <= n; i++) begin
         e = on_y ? y_edges[i] : x_edges[i];
         if (e <= v) at_or_below++;
      end
      bin = at_or_below - 1;
      if (bin >= n) bin = n - 1;
      return 1'b1;
   endfunction

   function automatic bin_report_type histogram_op(input logic [FUNC_W-1:0] fn,
                                                   input logic [INDEX_W-1:0] idx,
                                                   input logic signed [VALUE_WIDTH-1:0] xv,
                                                   input logic signed [VALUE_WIDTH-1:0] yv);
      int nx, ny, px, py, addr;
      bit hit_x, hit_y;
      bin_report_type r;
      r = '0;
      nx = bins_in_use(bins_x_reg);
      ny = bins_in_use(bins_y_reg);
      case (fn)
         FN_LOAD_X: begin
            if (idx < EDGE_DEPTH) x_edges[idx] = xv;
         end
         FN_LOAD_Y: begin
            if (idx < EDGE_DEPTH) y_edges[idx] = xv;
         end
         FN_ADD: begin
            if (samples_seen != TOTAL_MAX) samples_seen++;
            hit_x = find_bin(1'b0, nx, xv, px);
            hit_y = find_bin(1'b1, ny, yv, py);
            if (hit_x && hit_y) begin
               addr = py * nx + px;
               if (cell_counts[addr] != COUNT_SAT) cell_counts[addr]++;
               r.in_range = 1'b1;
               r.bin_x    = BIN_PORT_W'(px);
               r.bin_y    = BIN_PORT_W'(py);
               r.count    = cell_counts[addr];
            end
         end
         FN_READ: begin
            if (idx < nx * ny) begin
               r.in_range = 1'b1;
               r.bin_x    = BIN_PORT_W'(idx % nx);
               r.bin_y    = BIN_PORT_W'(idx / nx);
               r.count    = cell_counts[idx];
            end
         end
         FN_CLEAR: begin
            foreach (cell_counts[i]) cell_counts[i] = '0;
            samples_seen = '0;
         end
         default: ;
      endcase
      r.total = samples_seen;
      return r;
   endfunction

   function automatic void flag_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] got_v);
      if (exp_v !== got_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, got_v);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         foreach (x_edges[i]) x_edges[i] = '0;
         foreach (y_edges[i]) y_edges[i] = '0;
         foreach (cell_counts[i]) cell_counts[i] = '0;
         samples_seen = '0;
         bins_x_reg   = BINS_RESET;
         bins_y_reg   = BINS_RESET;
         fail_count   = 0;
         bin_reports.delete();
      end else begin
         if (rsp_valid) begin
            if (bin_reports.size() == 0) begin
               $error("rsp_valid: result with no item awaiting it");
               fail_count++;
            end else begin
               want = bin_reports.pop_front();
               flag_field("rsp_in_range", want.in_range, rsp_in_range);
               flag_field("rsp_bin_x", want.bin_x, rsp_bin_x);
               flag_field("rsp_bin_y", want.bin_y, rsp_bin_y);
               flag_field("rsp_count", want.count, rsp_count);
               flag_field("rsp_total", want.total, rsp_total);
            end
         end
         if (csr_wr_en) begin
            if (csr_index == CSR_BINS_X) bins_x_reg = csr_data;
            else bins_y_reg = csr_data;
         end
         if (start && !busy)
            bin_reports.insert(bin_reports.size(),
                               histogram_op(req_func, req_index, req_x_value,
                                            req_y_value));
      end
      outstanding <= bin_reports.size();
   end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

   import h2d_pkg::*;

   localparam int MAX_BINS   = 16;
   localparam int EDGE_DEPTH = MAX_BINS + 1;
   localparam int VALUE_MIN  = -32768;
   localparam int VALUE_MAX  = 32767;
   localparam int EDGE_STEP  = 4096;
   localparam int FILL_ITEMS = 24;
   localparam int PHASES     = 7;
   localparam logic [FUNC_W-1:0] FN_SPARE_LO = 3'd5;
   localparam logic [FUNC_W-1:0] FN_SPARE_HI = 3'd7;

   logic                      clock;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic [FUNC_W-1:0]         req_func;
   logic [INDEX_W-1:0]        req_index;
   logic signed [15:0]        req_x_value;
   logic signed [15:0]        req_y_value;
   logic                      rsp_valid;
   logic                      rsp_in_range;
   logic [BIN_PORT_W-1:0]     rsp_bin_x;
   logic [BIN_PORT_W-1:0]     rsp_bin_y;
   logic [15:0]               rsp_count;
   logic [TOTAL_W-1:0]        rsp_total;
   logic                      csr_wr_en;
   logic [CSR_INDEX_W-1:0]    csr_index;
   logic [BINS_REG_W-1:0]     csr_data;
   int                        fail_count;
   int                        outstanding;

   bit                        idle_on;
   int                        x_loaded [EDGE_DEPTH];
   int                        y_loaded [EDGE_DEPTH];
   int                        cfg_x [PHASES];
   int                        cfg_y [PHASES];

   histogram_2d_binning u_dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_func     (req_func),
      .req_index    (req_index),
      .req_x_value  (req_x_value),
      .req_y_value  (req_y_value),
      .rsp_valid    (rsp_valid),
      .rsp_in_range (rsp_in_range),
      .rsp_bin_x    (rsp_bin_x),
      .rsp_bin_y    (rsp_bin_y),
      .rsp_count    (rsp_count),
      .rsp_total    (rsp_total),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   h2d_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_func     (req_func),
      .req_index    (req_index),
      .req_x_value  (req_x_value),
      .req_y_value  (req_y_value),
      .rsp_valid    (rsp_valid),
      .rsp_in_range (rsp_in_range),
      .rsp_bin_x    (rsp_bin_x),
      .rsp_bin_y    (rsp_bin_y),
      .rsp_count    (rsp_count),
      .rsp_total    (rsp_total),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .fail_count   (fail_count),
      .outstanding  (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #1ms;
      $display("tb: failure");
      $finish;
   end

   function automatic int edge_of(input bit on_y, input int i);
      return on_y ? y_loaded[i] : x_loaded[i];
   endfunction

   function automatic int usable_bins(input int r);
      if (r < 1) return 1;
      if (r > MAX_BINS) return MAX_BINS;
      return r;
   endfunction

   // offer one item and hold it until the block takes it
   task automatic issue(input logic [FUNC_W-1:0] fn, input int idx, input int xv,
                        input int yv);
      int gap;
      logic [INDEX_W-1:0] ix;
      logic [15:0] xbits;
      ix = INDEX_W'(idx);
      xbits = 16'(xv);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 6);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start       <= 1'b1;
      req_func    <= fn;
      req_index   <= ix;
      req_x_value <= xbits;
      req_y_value <= 16'(yv);
      do @(posedge clock); while (busy);
      if (ix < EDGE_DEPTH) begin
         if (fn == FN_LOAD_X) x_loaded[ix] = int'($signed(xbits));
         if (fn == FN_LOAD_Y) y_loaded[ix] = int'($signed(xbits));
      end
   endtask

   // drop start and wait for every result to drain
   task automatic settle();
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic configure(input int bx, input int by);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_BINS_X;
      csr_data  <= BINS_REG_W'(bx);
      @(posedge clock);
      csr_index <= CSR_BINS_Y;
      csr_data  <= BINS_REG_W'(by);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // mostly rising edges with some repeats; now and then a stray value breaks the order
   task automatic load_axis(input bit on_y, input int n);
      int v, stride, i;
      v = ($urandom_range(0, 4) == 0) ? VALUE_MIN : VALUE_MIN + int'($urandom_range(0, 40000));
      stride = (VALUE_MAX - v) / (n + 1);
      for (i = 0; i <= n; i++) begin
         if (i > 0 && $urandom_range(0, 4) != 0) v += $urandom_range(1, 2 * stride + 1);
         if (v > VALUE_MAX || (i == n && $urandom_range(0, 3) == 0)) v = VALUE_MAX;
         issue(on_y ? FN_LOAD_Y : FN_LOAD_X, i,
               ($urandom_range(0, 24) == 0) ? int'($urandom) : v, $urandom);
      end
   endtask

   function automatic int pick_value(input bit on_y, input int n);
      int lo, hi, v;
      lo = edge_of(on_y, 0);
      hi = edge_of(on_y, n);
      case ($urandom_range(0, 9))
         0: v = $urandom;
         1: v = $urandom_range(0, 1) ? VALUE_MAX : VALUE_MIN;
         2, 3, 4: v = edge_of(on_y, $urandom_range(0, n));
         5, 6: v = edge_of(on_y, $urandom_range(0, n)) + ($urandom_range(0, 1) ? 1 : -1);
         default: v = (hi > lo) ? lo + int'($urandom_range(0, hi - lo)) : lo;
      endcase
      return v;
   endfunction

   task automatic run_mix(input int items, input int nx, input int ny);
      int k, sel, top_read;
      top_read = (nx * ny + 1 > 255) ? 255 : nx * ny + 1;
      for (k = 0; k < items; k++) begin
         sel = $urandom_range(0, 99);
         if (sel < 60)
            issue(FN_ADD, $urandom, pick_value(1'b0, nx), pick_value(1'b1, ny));
         else if (sel < 78)
            issue(FN_READ, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                       : $urandom_range(0, top_read),
                  $urandom, $urandom);
         else if (sel < 86)
            issue($urandom_range(0, 1) ? FN_LOAD_Y : FN_LOAD_X,
                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                              : $urandom_range(0, MAX_BINS),
                  pick_value(1'b0, nx), $urandom);
         else if (sel < 88)
            issue(FN_CLEAR, $urandom, $urandom, $urandom);
         else if (sel < 92)
            issue(FUNC_W'($urandom_range(FN_SPARE_LO, FN_SPARE_HI)), $urandom, $urandom,
                  $urandom);
         else
            issue(FN_ADD, $urandom, $urandom, $urandom);
      end
   endtask

   initial begin
      int i, p, nx, ny;
      start       = 1'b0;
      req_func    = FN_LOAD_X;
      req_index   = '0;
      req_x_value = '0;
      req_y_value = '0;
      csr_wr_en   = 1'b0;
      csr_index   = CSR_BINS_X;
      csr_data    = '0;
      reset       = 1'b1;
      idle_on     = 1'b1;
      cfg_x = '{1, 0, 31, 5, 16, 17, 3};
      cfg_y = '{1, 31, 0, 3, 1, 9, 16};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // all edges still zero: only a zero sample lands, in the clamped top bin
      issue(FN_READ, 0, 0, 0);
      issue(FN_ADD, 0, 0, 0);
      issue(FN_READ, 255, 0, 0);
      issue(FN_ADD, 0, 1, 0);
      issue(FN_ADD, 0, -1, 0);
      issue(FN_LOAD_X, EDGE_DEPTH, 123, 0);
      issue(FN_LOAD_Y, 255, -123, 0);
      for (i = FN_SPARE_LO; i <= FN_SPARE_HI; i++)
         issue(FUNC_W'(i), $urandom, $urandom, $urandom);
      issue(FN_CLEAR, 0, 0, 0);
      issue(FN_READ, 255, 0, 0);

      // even ramp across the full value range on both axes
      for (i = 0; i < EDGE_DEPTH; i++) begin
         issue(FN_LOAD_X, i, (i == MAX_BINS) ? VALUE_MAX : VALUE_MIN + i * EDGE_STEP, 0);
         issue(FN_LOAD_Y, i, (i == MAX_BINS) ? VALUE_MAX : VALUE_MIN + i * EDGE_STEP, 0);
      end
      issue(FN_ADD, 0, VALUE_MIN, VALUE_MIN);
      issue(FN_ADD, 0, VALUE_MAX, VALUE_MAX);
      issue(FN_ADD, 0, VALUE_MIN, VALUE_MAX);
      issue(FN_ADD, 0, x_loaded[5], y_loaded[9] - 1);
      issue(FN_READ, 0, 0, 0);
      issue(FN_READ, 255, 0, 0);
      run_mix(80, MAX_BINS, MAX_BINS);
      settle();

      for (p = 0; p < PHASES; p++) begin
         nx = usable_bins(cfg_x[p]);
         ny = usable_bins(cfg_y[p]);
         configure(cfg_x[p], cfg_y[p]);
         load_axis(1'b0, nx);
         load_axis(1'b1, ny);
         run_mix(60, nx, ny);
         settle();
      end

      // last stretch runs back to back: pile samples into a single bin
      idle_on = 1'b0;
      configure(1, 1);
      issue(FN_LOAD_X, 0, VALUE_MIN, 0);
      issue(FN_LOAD_X, 1, VALUE_MAX, 0);
      issue(FN_LOAD_Y, 0, VALUE_MIN, 0);
      issue(FN_LOAD_Y, 1, VALUE_MAX, 0);
      for (i = 0; i < FILL_ITEMS; i++)
         issue(FN_ADD, $urandom, $urandom, $urandom);
      issue(FN_READ, 0, 0, 0);
      run_mix(40, 1, 1);
      issue(FN_CLEAR, 0, 0, 0);
      issue(FN_READ, 0, 0, 0);
      settle();

      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
